// ===== rtl/core/ulog_pkg.sv =====
package ulog_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned OUT_CNT_W  = 11;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned ALIGN_BITS = $clog2(WORD_BYTES);

  localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_STORE   = 2'd0,
    CMD_CKPT    = 2'd1,
    CMD_RESTORE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PROT_ERR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROTECT_BASE  = 2'd0,
    REG_PROTECT_LIMIT = 2'd1,
    REG_STACK_THRESH  = 2'd2,
    REG_KEEP_STACK    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] store_address;
    logic [WORD_W-1:0] old_word;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic                 restore_valid;
    logic [ADDR_W-1:0]    restore_address;
    logic [WORD_W-1:0]    restore_word;
    logic                 is_stack_entry;
    logic                 last;
    logic [OUT_CNT_W-1:0] log_count;
    logic [OUT_CNT_W-1:0] stack_skipped;
    logic                 fail_stop;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [63:0]          value;
  } cfg_item_t;

  // Shift controls broadcast along the cell chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ===== rtl/core/ulog_chan_if.sv =====
interface ulog_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ulog_cell.sv =====
module ulog_cell import ulog_pkg::*; (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  entry_t     from_above,
  input  entry_t     from_below,
  output entry_t     entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A push moves every entry one cell deeper; a pop pulls them one cell up.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      entry_nxt = from_above;
    end else if (ctl.pop) begin
      entry_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/core/undo_log_engine_top.sv =====
// Channel  Dir  Payload                                   Handshake
// in_ch    in   cmd, store_address, old_word              valid/ready
// out_ch   out  status, restore fields, counts, fail_stop valid/ready
// cfg_ch   in   index, value                              valid/ready, always ready
//
// One word is taken per cycle; its result is registered and shows up on out_ch in
// the following cycle. The log is a chain of LOG_DEPTH cells that shifts by one
// cell per push or pop. Input is held off only while a result waits and out_ch
// is stalled. Synchronous reset clears the counters and the fail flag and opens
// the logging window; the log cells need no clearing.
module undo_log_engine_top import ulog_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input logic   clk,
  input logic   rst_n,
  ulog_chan_if.sink   in_ch,
  ulog_chan_if.source out_ch,
  ulog_chan_if.sink   cfg_ch
);

  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);

  logic [ADDR_W-1:0] protect_base_r;
  logic [ADDR_W-1:0] protect_limit_r;
  logic [ADDR_W-1:0] stack_thresh_r;
  logic              keep_stack_r;

  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic                 window_r, window_nxt;
  logic                 fail_r, fail_nxt;
  logic [OUT_CNT_W-1:0] stack_cnt_r, stack_cnt_nxt;
  logic                 out_valid_r;
  out_item_t            out_r, res;

  logic       in_acc;
  logic       cfg_acc;
  shift_ctl_t ctl;
  entry_t     new_entry;
  entry_t     chain [LOG_DEPTH];

  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [EXT_W-1:0] v);
    if (v > EXT_W'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return v[OUT_CNT_W-1:0];
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protect_base_r  <= '0;
      protect_limit_r <= '0;
      stack_thresh_r  <= '1;
      keep_stack_r    <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_ch.data.index)
        REG_PROTECT_BASE:  protect_base_r  <= cfg_ch.data.value;
        REG_PROTECT_LIMIT: protect_limit_r <= cfg_ch.data.value;
        REG_STACK_THRESH:  stack_thresh_r  <= cfg_ch.data.value;
        REG_KEEP_STACK:    keep_stack_r    <= cfg_ch.data.value[0];
        default: ;
      endcase
    end
  end

  // Store path: aligned address against the protected region.
  logic [ADDR_W-1:0] st_addr;
  logic              st_prot;
  assign st_addr = {in_ch.data.store_address[ADDR_W-1:ALIGN_BITS], ALIGN_BITS'(0)};
  assign st_prot = (st_addr >= protect_base_r) && (st_addr < protect_limit_r);
  assign new_entry.addr = st_addr;
  assign new_entry.word = in_ch.data.old_word;

  // Restore path: the newest entry always sits in the head cell.
  entry_t            head;
  logic [ADDR_W-1:0] base_gap;
  logic              pop_prot;
  logic              pop_stack;
  assign head      = chain[0];
  assign base_gap  = protect_base_r - head.addr;
  // The popped word is protected if any of its bytes lands inside the region.
  assign pop_prot  = (protect_limit_r > protect_base_r) && (head.addr < protect_limit_r) &&
                     ((head.addr >= protect_base_r) ||
                      (base_gap[ADDR_W-1:ALIGN_BITS] == '0));
  assign pop_stack = head.addr > stack_thresh_r;

  always_comb begin
    logic [OUT_CNT_W-1:0] stack_inc;
    res           = '0;
    res.status    = ST_OK;
    fill_nxt      = fill_r;
    window_nxt    = window_r;
    fail_nxt      = fail_r;
    stack_cnt_nxt = stack_cnt_r;
    stack_inc     = stack_cnt_r;
    ctl           = '0;
    res.log_count = sat_cnt(EXT_W'(fill_r));

    case (in_ch.data.cmd)
      CMD_STORE: begin
        if (!window_r) begin
          res.status = ST_OVERFLOW;
        end else if (st_prot) begin
          res.status = ST_PROT_ERR;
        end else begin
          if (fill_r < DEPTH_CNT) begin
            ctl.push = in_acc;
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (fill_nxt >= DEPTH_CNT) begin
            window_nxt = 1'b0;
            fail_nxt   = 1'b1;
            res.status = ST_OVERFLOW;
          end
        end
        res.log_count = sat_cnt(EXT_W'(fill_nxt));
      end
      CMD_CKPT: begin
        fill_nxt      = '0;
        window_nxt    = 1'b1;
        stack_cnt_nxt = '0;
        stack_inc     = '0;
      end
      CMD_RESTORE: begin
        if ((fill_r == '0) || (fill_r > DEPTH_CNT)) begin
          res.status = ST_EMPTY;
        end else begin
          ctl.pop             = in_acc;
          fill_nxt            = fill_r - CNT_W'(1);
          res.restore_address = head.addr;
          res.restore_word    = head.word;
          res.is_stack_entry  = pop_stack;
          res.restore_valid   = !pop_prot && (!pop_stack || keep_stack_r) &&
                                (head.addr != '0);
          res.last            = (fill_nxt == '0);
          if (!pop_prot && pop_stack && (stack_cnt_r != COUNT_MAX)) begin
            stack_inc = stack_cnt_r + OUT_CNT_W'(1);
          end
          // The pop that empties the log ends the restore run.
          stack_cnt_nxt = res.last ? '0 : stack_inc;
        end
        res.log_count = sat_cnt(EXT_W'(fill_nxt));
      end
      default: ;
    endcase

    res.stack_skipped = stack_inc;
    res.fail_stop     = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      window_r    <= 1'b1;
      fail_r      <= 1'b0;
      stack_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_r      <= fill_nxt;
        window_r    <= window_nxt;
        fail_r      <= fail_nxt;
        stack_cnt_r <= stack_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_head
      assign above = new_entry;
    end else begin : g_body
      assign above = chain[i-1];
    end
    if (i == LOG_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_inner
      assign below = chain[i+1];
    end
    ulog_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .entry      (chain[i])
    );
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_CNT)
    else $error("log fill count exceeds depth");

  a_open_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    window_r |-> (fill_r < DEPTH_CNT))
    else $error("logging window open on a full log");

  a_ckpt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.data.cmd == CMD_CKPT)) |=> ((fill_r == '0) && window_r &&
                                                 (stack_cnt_r == '0)))
    else $error("checkpoint did not clear the log");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |=> fail_r)
    else $error("fail-stop flag cleared without reset");

  a_no_shift_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("cell chain asked to push and pop together");

endmodule
